[sv/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types, codes and default sizes of the padded 2D convolution engine.
// ----------------------------------------------------------------------------
package c2d_pkg;

    localparam int unsigned DEF_IMAGE_WORDS  = 4096;
    localparam int unsigned DEF_WEIGHT_WORDS = 4096;
    localparam int unsigned DEF_OUTPUT_WORDS = 4096;
    localparam int unsigned DEF_DATA_WIDTH   = 16;
    localparam int unsigned DEF_ACC_WIDTH    = 48;

    localparam int unsigned ADDR_W   = 12;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned READ_W   = 48;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 7;
    // signed image pointer, wide enough for any padded row offset
    localparam int unsigned PTR_W    = 24;

    typedef enum logic [1:0] {
        CMD_WR_IMAGE  = 2'd0,
        CMD_WR_WEIGHT = 2'd1,
        CMD_COMPUTE   = 2'd2,
        CMD_READ_OUT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_ADDR = 2'd1,
        STAT_NO_FIT   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_H  = 4'd0,
        REG_IMAGE_W  = 4'd1,
        REG_IN_CH    = 4'd2,
        REG_KERNEL_H = 4'd3,
        REG_KERNEL_W = 4'd4,
        REG_OUT_CH   = 4'd5,
        REG_PAD_ROWS = 4'd6,
        REG_PAD_COLS = 4'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIM,
        ST_PROD,
        ST_SIZE,
        ST_DECIDE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

[sv/conv2d_padded_nhwc_engine_unit.sv]
// ----------------------------------------------------------------------------
// conv2d_padded_nhwc_engine_unit
// Stride-1 zero-padded 2D convolution over an HWC image and HWIO weights.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/i_command/i_address/i_sample and are taken at a
//   rising edge with start high and busy low. Each item yields one result on
//   o_status/o_read_value/o_done_res, shown for one cycle with o_valid high.
//   The receiver cannot stall; every result must be taken as it appears.
//   Image write, weight write and output read: the result is registered and
//   appears in the cycle after the item, and busy stays low, so one item per
//   cycle is sustained.
//   Compute holds busy high. The DIM, PROD, SIZE and DECIDE states size the
//   job and check that it fits, then the tap sequencer issues one tap
//   (fh, fw, c) per cycle for every output element, and the DRAIN state
//   empties the read/multiply/accumulate pipe. The single MAC and one memory
//   read port per store bound the tap rate. A job that does not fit answers
//   from DECIDE with the no-fit status and leaves the outputs untouched.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data only
//   while idle, a rule on the user that the block leaves unchecked; indexes
//   beyond the register list are dropped. Reset (synchronous, active low)
//   restores the register defaults and idle; the stores keep no reset value.
// ----------------------------------------------------------------------------
module conv2d_padded_nhwc_engine_unit
    import c2d_pkg::*;
#(
    parameter int unsigned IMAGE_WORDS  = DEF_IMAGE_WORDS,
    parameter int unsigned WEIGHT_WORDS = DEF_WEIGHT_WORDS,
    parameter int unsigned OUTPUT_WORDS = DEF_OUTPUT_WORDS,
    parameter int unsigned DATA_WIDTH   = DEF_DATA_WIDTH,
    parameter int unsigned ACC_WIDTH    = DEF_ACC_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [ADDR_W-1:0]           i_address,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic signed [READ_W-1:0]    o_read_value,
    output logic                        o_done_res,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int unsigned IMG_AW = $clog2(IMAGE_WORDS);
    localparam int unsigned WGT_AW = $clog2(WEIGHT_WORDS);
    localparam int unsigned OUT_AW = $clog2(OUTPUT_WORDS);
    localparam int unsigned PROD_W = 2 * DATA_WIDTH;
    localparam int unsigned SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
    localparam logic signed [SUM_W-1:0] ACC_HI =
        SUM_W'(signed'({1'b0, {(ACC_WIDTH-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);

    // ---------------- configuration registers ----------------
    logic [6:0] r_h, r_w, r_ch, r_m_cnt;
    logic [4:0] r_fh_cnt, r_fw_cnt;
    logic [3:0] r_ph, r_pw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h      <= 7'd8;
            r_w      <= 7'd8;
            r_ch     <= 7'd1;
            r_fh_cnt <= 5'd3;
            r_fw_cnt <= 5'd3;
            r_m_cnt  <= 7'd1;
            r_ph     <= 4'd1;
            r_pw     <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_H:  r_h      <= i_cfg_data;
                REG_IMAGE_W:  r_w      <= i_cfg_data;
                REG_IN_CH:    r_ch     <= i_cfg_data;
                REG_KERNEL_H: r_fh_cnt <= i_cfg_data[4:0];
                REG_KERNEL_W: r_fw_cnt <= i_cfg_data[4:0];
                REG_OUT_CH:   r_m_cnt  <= i_cfg_data;
                REG_PAD_ROWS: r_ph     <= i_cfg_data[3:0];
                REG_PAD_COLS: r_pw     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- stores ----------------
    logic signed [DATA_WIDTH-1:0] mem_img [IMAGE_WORDS];
    logic signed [DATA_WIDTH-1:0] mem_wgt [WEIGHT_WORDS];
    logic signed [ACC_WIDTH-1:0]  mem_out [OUTPUT_WORDS];

    logic signed [DATA_WIDTH-1:0] r_img_q, r_wgt_q;
    logic signed [ACC_WIDTH-1:0]  r_out_q;

    t_state r_state, n_state;

    // accepted command decode
    logic accept;
    logic img_ok, wgt_ok, out_ok;
    assign accept = start && (r_state == ST_IDLE);
    assign img_ok = 32'(i_address) < IMAGE_WORDS;
    assign wgt_ok = 32'(i_address) < WEIGHT_WORDS;
    assign out_ok = 32'(i_address) < OUTPUT_WORDS;

    // ---------------- sizing ----------------
    logic [8:0]  r_oh_n, r_ow_n;
    logic [13:0] r_hw, r_wc, r_fhfw;
    logic [15:0] r_ohow;
    logic [10:0] r_pwc;
    logic [20:0] r_img_n;
    logic [22:0] r_out_n;
    logic [16:0] r_wcn;
    logic [17:0] r_phwc;
    logic [23:0] r_wgt_n;
    logic        r_zero;
    logic        fit;

    always_ff @(posedge i_clk) begin
        // DIM: output sizes and first products
        r_oh_n <= {2'b0, r_h} + {4'b0, r_ph, 1'b0} - {4'b0, r_fh_cnt} + 9'd1;
        r_ow_n <= {2'b0, r_w} + {4'b0, r_pw, 1'b0} - {4'b0, r_fw_cnt} + 9'd1;
        r_hw   <= r_h * r_w;
        r_wc   <= r_w * r_ch;
        r_fhfw <= r_fh_cnt * r_fw_cnt;
        r_pwc  <= r_pw * r_ch;
        r_zero <= (r_h == '0) || (r_w == '0) || (r_ch == '0) || (r_fh_cnt == '0)
               || (r_fw_cnt == '0) || (r_m_cnt == '0);
        // PROD
        r_img_n <= r_hw * r_ch;
        r_wcn   <= r_fhfw * r_ch;
        r_ohow  <= r_oh_n[7:0] * r_ow_n[7:0];
        r_phwc  <= r_ph * r_wc;
        // SIZE
        r_wgt_n <= r_wcn * r_m_cnt;
        r_out_n <= r_ohow * r_m_cnt;
    end

    assign fit = !r_zero && !r_oh_n[8] && (r_oh_n != '0) && !r_ow_n[8] && (r_ow_n != '0)
              && (32'(r_img_n) <= IMAGE_WORDS) && (32'(r_wgt_n) <= WEIGHT_WORDS)
              && (32'(r_out_n) <= OUTPUT_WORDS);

    // ---------------- tap sequencer ----------------
    logic [7:0] r_oh, r_ow;
    logic [6:0] r_mi, r_c;
    logic [4:0] r_fhi, r_fwi;
    logic signed [8:0] r_ih0, r_iw0;
    logic [PTR_W-1:0] r_orow, r_opix, r_trow, r_tpix;
    logic [WGT_AW-1:0] r_waddr;
    logic [OUT_AW-1:0] r_oaddr;

    logic [8:0] ih, iw;
    logic       in_rng;
    logic       last_c, last_fw, last_fh, last_m, last_ow, last_oh, last_tap;
    logic [PTR_W-1:0] tap_ptr, init_ptr;

    assign ih = r_ih0 + {4'b0, r_fhi};
    assign iw = r_iw0 + {4'b0, r_fwi};
    assign in_rng = !ih[8] && (ih[7:0] < {1'b0, r_h}) && !iw[8] && (iw[7:0] < {1'b0, r_w});
    assign tap_ptr = r_tpix + PTR_W'(r_c);
    assign init_ptr = PTR_W'(0) - PTR_W'(r_phwc) - PTR_W'(r_pwc);

    assign last_c   = (r_c == r_ch - 7'd1);
    assign last_fw  = (r_fwi == r_fw_cnt - 5'd1);
    assign last_fh  = (r_fhi == r_fh_cnt - 5'd1);
    assign last_m   = (r_mi == r_m_cnt - 7'd1);
    assign last_ow  = ({1'b0, r_ow} == r_ow_n - 9'd1);
    assign last_oh  = ({1'b0, r_oh} == r_oh_n - 9'd1);
    assign last_tap = last_c && last_fw && last_fh;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE) begin
            r_oh    <= '0;
            r_ow    <= '0;
            r_mi    <= '0;
            r_fhi   <= '0;
            r_fwi   <= '0;
            r_c     <= '0;
            r_ih0   <= -$signed({5'b0, r_ph});
            r_iw0   <= -$signed({5'b0, r_pw});
            r_orow  <= init_ptr;
            r_opix  <= init_ptr;
            r_trow  <= init_ptr;
            r_tpix  <= init_ptr;
            r_waddr <= '0;
            r_oaddr <= '0;
        end else if (r_state == ST_RUN) begin
            r_waddr <= r_waddr + WGT_AW'(r_m_cnt);
            if (!last_c) begin
                r_c <= r_c + 7'd1;
            end else begin
                r_c <= '0;
                if (!last_fw) begin
                    r_fwi  <= r_fwi + 5'd1;
                    r_tpix <= r_tpix + PTR_W'(r_ch);
                end else begin
                    r_fwi <= '0;
                    if (!last_fh) begin
                        r_fhi  <= r_fhi + 5'd1;
                        r_trow <= r_trow + PTR_W'(r_wc);
                        r_tpix <= r_trow + PTR_W'(r_wc);
                    end else begin
                        // output element finished: advance m, then ow, then oh
                        r_fhi   <= '0;
                        r_oaddr <= r_oaddr + OUT_AW'(1);
                        if (!last_m) begin
                            r_mi    <= r_mi + 7'd1;
                            r_waddr <= WGT_AW'(r_mi + 7'd1);
                            r_trow  <= r_opix;
                            r_tpix  <= r_opix;
                        end else begin
                            r_mi    <= '0;
                            r_waddr <= '0;
                            if (!last_ow) begin
                                r_ow   <= r_ow + 8'd1;
                                r_iw0  <= r_iw0 + 9'sd1;
                                r_opix <= r_opix + PTR_W'(r_ch);
                                r_trow <= r_opix + PTR_W'(r_ch);
                                r_tpix <= r_opix + PTR_W'(r_ch);
                            end else begin
                                r_ow   <= '0;
                                r_oh   <= r_oh + 8'd1;
                                r_iw0  <= -$signed({5'b0, r_pw});
                                r_ih0  <= r_ih0 + 9'sd1;
                                r_orow <= r_orow + PTR_W'(r_wc);
                                r_opix <= r_orow + PTR_W'(r_wc);
                                r_trow <= r_orow + PTR_W'(r_wc);
                                r_tpix <= r_orow + PTR_W'(r_wc);
                            end
                        end
                    end
                end
            end
        end
    end

    // ---------------- MAC pipeline ----------------
    logic                   r_p1_valid, r_p2_valid;
    logic                   r_p1_use, r_p1_first, r_p1_last;
    logic                   r_p2_first, r_p2_last;
    logic [OUT_AW-1:0]      r_p1_oaddr, r_p2_oaddr;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_WIDTH-1:0] r_acc;
    logic signed [SUM_W-1:0] sum;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic issue;

    assign issue = (r_state == ST_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_use   <= in_rng;
        r_p1_first <= (r_c == '0) && (r_fwi == '0) && (r_fhi == '0);
        r_p1_last  <= last_tap;
        r_p1_oaddr <= r_oaddr;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_oaddr <= r_p1_oaddr;
        // gate out-of-image taps to zero
        r_prod     <= r_p1_use ? PROD_W'(r_img_q) * PROD_W'(r_wgt_q) : '0;
    end

    // saturating accumulate, restart at the first tap of each element
    always_comb begin
        sum = (r_p2_first ? SUM_W'(0) : SUM_W'(r_acc)) + SUM_W'(r_prod);
        priority if (sum > ACC_HI) begin
            acc_next = ACC_WIDTH'(ACC_HI);
        end else if (sum < ACC_LO) begin
            acc_next = ACC_WIDTH'(ACC_LO);
        end else begin
            acc_next = ACC_WIDTH'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_valid) begin
            r_acc <= acc_next;
        end
    end

    // ---------------- memory ports ----------------
    always_ff @(posedge i_clk) begin
        if (accept && (i_command == CMD_WR_IMAGE) && img_ok) begin
            mem_img[IMG_AW'(i_address)] <= DATA_WIDTH'(i_sample);
        end
        r_img_q <= mem_img[IMG_AW'(tap_ptr)];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_command == CMD_WR_WEIGHT) && wgt_ok) begin
            mem_wgt[WGT_AW'(i_address)] <= DATA_WIDTH'(i_sample);
        end
        r_wgt_q <= mem_wgt[r_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_valid && r_p2_last) begin
            mem_out[r_p2_oaddr] <= acc_next;
        end
        r_out_q <= mem_out[OUT_AW'(i_address)];
    end

    // ---------------- control FSM ----------------
    logic pipe_empty;
    assign pipe_empty = !r_p1_valid && !r_p2_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept && (i_command == CMD_COMPUTE)) n_state = ST_DIM;
            ST_DIM:    n_state = ST_PROD;
            ST_PROD:   n_state = ST_SIZE;
            ST_SIZE:   n_state = ST_DECIDE;
            ST_DECIDE: n_state = fit ? ST_RUN : ST_IDLE;
            ST_RUN:    if (last_tap && last_m && last_ow && last_oh) n_state = ST_DRAIN;
            ST_DRAIN:  if (pipe_empty) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- result ----------------
    logic    r_valid, n_valid;
    t_status r_status, n_status;
    logic    r_done, n_done;
    logic    r_is_read, n_is_read;

    always_comb begin
        n_valid   = 1'b0;
        n_status  = STAT_OK;
        n_done    = 1'b0;
        n_is_read = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        CMD_WR_IMAGE: begin
                            n_valid  = 1'b1;
                            n_status = img_ok ? STAT_OK : STAT_BAD_ADDR;
                        end
                        CMD_WR_WEIGHT: begin
                            n_valid  = 1'b1;
                            n_status = wgt_ok ? STAT_OK : STAT_BAD_ADDR;
                        end
                        CMD_READ_OUT: begin
                            n_valid   = 1'b1;
                            n_status  = out_ok ? STAT_OK : STAT_BAD_ADDR;
                            n_is_read = out_ok;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DECIDE: begin
                if (!fit) begin
                    n_valid  = 1'b1;
                    n_status = STAT_NO_FIT;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_valid = 1'b1;
                    n_done  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_status  <= n_status;
        r_done    <= n_done;
        r_is_read <= n_is_read;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_done_res   = r_done;
    assign o_read_value = r_is_read ? READ_W'(r_out_q) : '0;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the padded 2D convolution engine. Loads images and
// weights, runs compute jobs across many register settings (defaults,
// extremes, configurations that do not fit) and reads back outputs. Every
// result is checked against an in-bench convolution predictor.
// ----------------------------------------------------------------------------
module testbench;
    import c2d_pkg::*;

    localparam int unsigned IMG_DEPTH = DEF_IMAGE_WORDS;
    localparam int unsigned WGT_DEPTH = DEF_WEIGHT_WORDS;
    localparam int unsigned OUT_DEPTH = DEF_OUTPUT_WORDS;
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int unsigned ITEM_GOAL = 1000;
    localparam logic [CFG_IDX_W-1:0] REG_BEYOND = 4'(REG_PAD_COLS) + 4'd1;

    typedef struct {
        t_cmd               cmd;
        logic [ADDR_W-1:0]  addr;
        logic signed [15:0] sample;
    } t_conv_item;

    typedef struct {
        t_status            status;
        logic signed [47:0] value;
        logic               done;
    } t_conv_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_command = '0;
    logic [ADDR_W-1:0] i_address = '0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic o_valid;
    logic [1:0] o_status;
    logic signed [READ_W-1:0] o_read_value;
    logic o_done_res;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    conv2d_padded_nhwc_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_address(i_address), .i_sample(i_sample),
        .o_valid(o_valid), .o_status(o_status), .o_read_value(o_read_value),
        .o_done_res(o_done_res), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: registers and the three stores
    int unsigned        conv_regs [NUM_REGS];
    logic signed [15:0] image_mem [IMG_DEPTH];
    logic signed [15:0] weight_mem [WGT_DEPTH];
    logic signed [47:0] out_mem [OUT_DEPTH];

    t_conv_item   pending_items [$];
    t_conv_result expected_results [$];
    t_conv_item   cur_item;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned computes_ok = 0;
    int unsigned computes_nofit = 0;
    int unsigned phase_count = 0;
    int unsigned idle_gap = 0;
    bit          no_idle = 0;

    // Sizes of the job under the current registers; return the status.
    function automatic t_status job_shape(output int oh_n, output int ow_n);
        int h, w, c, fh, fw, m;
        h = conv_regs[REG_IMAGE_H];  w = conv_regs[REG_IMAGE_W];
        c = conv_regs[REG_IN_CH];    fh = conv_regs[REG_KERNEL_H];
        fw = conv_regs[REG_KERNEL_W]; m = conv_regs[REG_OUT_CH];
        oh_n = h + 2 * int'(conv_regs[REG_PAD_ROWS]) - fh + 1;
        ow_n = w + 2 * int'(conv_regs[REG_PAD_COLS]) - fw + 1;
        if (h == 0 || w == 0 || c == 0 || fh == 0 || fw == 0 || m == 0)
            return STAT_NO_FIT;
        if (oh_n < 1 || ow_n < 1)
            return STAT_NO_FIT;
        if (h * w * c > IMG_DEPTH || fh * fw * c * m > WGT_DEPTH ||
            oh_n * ow_n * m > OUT_DEPTH)
            return STAT_NO_FIT;
        return STAT_OK;
    endfunction

    function automatic longint sat_acc(longint acc, longint p);
        longint hi, lo;
        hi = (longint'(1) <<< 47) - 1;
        lo = -hi - 1;
        if (p > 0 && acc > hi - p) return hi;
        if (p < 0 && acc < lo - p) return lo;
        return acc + p;
    endfunction

    // Fill the output store the way the engine should.
    function automatic void convolve();
        int oh_n, ow_n, h, w, c, fh_n, fw_n, m_n, ph, pw, ih, iw;
        longint acc;
        void'(job_shape(oh_n, ow_n));
        h = conv_regs[REG_IMAGE_H];  w = conv_regs[REG_IMAGE_W];
        c = conv_regs[REG_IN_CH];    fh_n = conv_regs[REG_KERNEL_H];
        fw_n = conv_regs[REG_KERNEL_W]; m_n = conv_regs[REG_OUT_CH];
        ph = conv_regs[REG_PAD_ROWS]; pw = conv_regs[REG_PAD_COLS];
        for (int oh = 0; oh < oh_n; oh++)
            for (int ow = 0; ow < ow_n; ow++)
                for (int m = 0; m < m_n; m++) begin
                    acc = 0;
                    for (int fh = 0; fh < fh_n; fh++) begin
                        ih = oh + fh - ph;
                        if (ih < 0 || ih >= h) continue;
                        for (int fw = 0; fw < fw_n; fw++) begin
                            iw = ow + fw - pw;
                            if (iw < 0 || iw >= w) continue;
                            for (int ci = 0; ci < c; ci++)
                                acc = sat_acc(acc,
                                    longint'(image_mem[(ih * w + iw) * c + ci]) *
                                    longint'(weight_mem[((fh * fw_n + fw) * c + ci)
                                                        * m_n + m]));
                        end
                    end
                    out_mem[(oh * ow_n + ow) * m_n + m] = acc[47:0];
                end
    endfunction

    function automatic t_conv_result predict_result(t_conv_item it);
        t_conv_result r;
        int oh_n, ow_n;
        r.status = STAT_OK; r.value = '0; r.done = 1'b0;
        case (it.cmd)
            CMD_WR_IMAGE:  image_mem[it.addr] = it.sample;
            CMD_WR_WEIGHT: weight_mem[it.addr] = it.sample;
            CMD_COMPUTE: begin
                r.status = job_shape(oh_n, ow_n);
                if (r.status == STAT_OK) begin
                    convolve();
                    r.done = 1'b1;
                end
            end
            default: r.value = out_mem[it.addr];
        endcase
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
    endtask

    // Driver: hold the item until taken, then advance after an optional gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_result(cur_item));
                items_taken++;
            end
            if (!start || !busy) begin
                if (idle_gap > 0) begin
                    idle_gap <= idle_gap - 1;
                    start <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    i_command <= cur_item.cmd;
                    i_address <= cur_item.addr;
                    i_sample <= cur_item.sample;
                    start <= 1'b1;
                    idle_gap <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_conv_result want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_read_value !== want.value)
                    report_mismatch("read_value", o_read_value, want.value);
                if (o_done_res !== want.done)
                    report_mismatch("done_res", o_done_res, want.done);
                if (want.done) computes_ok++;
                if (want.status == STAT_NO_FIT) computes_nofit++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    // generation-time record of which output entries hold defined data
    bit out_set [OUT_DEPTH];

    function automatic logic signed [15:0] rand_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return 16'sh7FFF;
        if (r < 8) return -16'sh8000;
        if (r < 10) return 16'sh0000;
        if (r < 12) return -16'sh0001;
        return 16'($urandom);
    endfunction

    task automatic queue_item(t_cmd cmd, int unsigned addr, logic signed [15:0] s);
        t_conv_item it;
        int oh_n, ow_n;
        it.cmd = cmd; it.addr = addr[ADDR_W-1:0]; it.sample = s;
        pending_items.push_back(it);
        items_queued++;
        if (cmd == CMD_COMPUTE && job_shape(oh_n, ow_n) == STAT_OK)
            for (int i = 0; i < oh_n * ow_n * int'(conv_regs[REG_OUT_CH]); i++)
                out_set[i] = 1;
    endtask

    // Wait until the engine is idle and nothing is outstanding.
    task automatic drain();
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (8) @(posedge i_clk);
        while (busy || start) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        int unsigned bits;
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        if (idx < NUM_REGS) begin
            bits = (idx == REG_KERNEL_H || idx == REG_KERNEL_W) ? 5 :
                   (idx == REG_PAD_ROWS || idx == REG_PAD_COLS) ? 4 : 7;
            conv_regs[idx] = val & ((1 << bits) - 1);
        end
    endtask

    task automatic set_shape(int unsigned h, int unsigned w, int unsigned c,
                             int unsigned fh, int unsigned fw, int unsigned m,
                             int unsigned ph, int unsigned pw);
        drain();
        write_reg(REG_IMAGE_H, h);  write_reg(REG_IMAGE_W, w);
        write_reg(REG_IN_CH, c);    write_reg(REG_KERNEL_H, fh);
        write_reg(REG_KERNEL_W, fw); write_reg(REG_OUT_CH, m);
        write_reg(REG_PAD_ROWS, ph); write_reg(REG_PAD_COLS, pw);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phase_count++;
    endtask

    // Load the whole image and filter, compute, then read back and mix.
    task automatic run_job(int unsigned n_mix);
        int oh_n, ow_n, n_img, n_wgt, n_out;
        int unsigned r, a;
        if (job_shape(oh_n, ow_n) != STAT_OK) begin
            queue_item(CMD_COMPUTE, $urandom, rand_sample());
            return;
        end
        no_idle = ($urandom_range(0, 3) == 0);
        n_img = conv_regs[REG_IMAGE_H] * conv_regs[REG_IMAGE_W] * conv_regs[REG_IN_CH];
        n_wgt = conv_regs[REG_KERNEL_H] * conv_regs[REG_KERNEL_W] *
                conv_regs[REG_IN_CH] * conv_regs[REG_OUT_CH];
        n_out = oh_n * ow_n * int'(conv_regs[REG_OUT_CH]);
        for (int i = 0; i < n_img; i++) queue_item(CMD_WR_IMAGE, i, rand_sample());
        for (int i = 0; i < n_wgt; i++) queue_item(CMD_WR_WEIGHT, i, rand_sample());
        queue_item(CMD_COMPUTE, $urandom, rand_sample());
        for (int i = 0; i < n_out && i < 48; i++) queue_item(CMD_READ_OUT, i, 16'(i));
        for (int unsigned i = 0; i < n_mix; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                a = $urandom_range(0, n_img - 1);
                if (r < 5) a = $urandom_range(0, IMG_DEPTH - 1);
                queue_item(CMD_WR_IMAGE, a, rand_sample());
            end else if (r < 55) begin
                a = $urandom_range(0, n_wgt - 1);
                if (r < 35) a = $urandom_range(0, WGT_DEPTH - 1);
                queue_item(CMD_WR_WEIGHT, a, rand_sample());
            end else if (r < 62) begin
                queue_item(CMD_COMPUTE, $urandom, rand_sample());
            end else begin
                a = $urandom_range(0, OUT_DEPTH - 1);
                if (!out_set[a]) a = $urandom_range(0, n_out - 1);
                queue_item(CMD_READ_OUT, a, rand_sample());
            end
        end
    endtask

    initial begin
        int unsigned h, w, c, fh, fw, m, ph, pw;
        int oh_n, ow_n;
        conv_regs = '{8, 8, 1, 3, 3, 1, 1, 1};
        foreach (image_mem[i]) image_mem[i] = '0;
        foreach (weight_mem[i]) weight_mem[i] = '0;
        foreach (out_mem[i]) out_mem[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: store edges with extreme data, then default-shape job
        queue_item(CMD_WR_IMAGE, IMG_DEPTH - 1, 16'sh7FFF);
        queue_item(CMD_WR_WEIGHT, WGT_DEPTH - 1, -16'sh8000);
        queue_item(CMD_WR_IMAGE, 0, -16'sh8000);
        queue_item(CMD_WR_WEIGHT, 0, 16'sh7FFF);
        run_job(10);

        // configurations that do not fit: zero size, stores overflowed, kernel
        // taller than the padded image, and a masked over-wide kernel value
        set_shape(0, 8, 1, 3, 3, 1, 1, 1);   run_job(0);
        set_shape(64, 64, 64, 16, 16, 64, 15, 15); run_job(0);
        set_shape(1, 4, 1, 16, 1, 1, 0, 0);  run_job(0);
        set_shape(4, 4, 1, 127, 3, 1, 1, 1); run_job(0);
        // write to an index beyond the register list; must be dropped
        drain();
        write_reg(REG_BEYOND, 7'h55);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;

        // largest pad and a 16x16 kernel on a tiny image
        set_shape(2, 2, 1, 16, 16, 1, 15, 15); run_job(10);
        // wide channel fan in and out
        set_shape(1, 1, 8, 1, 1, 8, 0, 0); run_job(10);
        // a 64-row image, one column wide
        set_shape(64, 1, 1, 1, 1, 1, 0, 0); run_job(20);
        // one-pixel job
        set_shape(1, 1, 1, 1, 1, 1, 0, 0); run_job(20);

        // random shapes, mostly small
        while (items_queued < ITEM_GOAL) begin
            h = $urandom_range(1, 6);  w = $urandom_range(1, 6);
            c = $urandom_range(1, 3);  fh = $urandom_range(1, 4);
            fw = $urandom_range(1, 4); m = $urandom_range(1, 3);
            ph = $urandom_range(0, 3); pw = $urandom_range(0, 3);
            set_shape(h, w, c, fh, fw, m, ph, pw);
            run_job($urandom_range(20, 60));
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d items over %0d register settings", items_taken, phase_count);
        $display("computes: %0d finished, %0d rejected as not fitting",
                 computes_ok, computes_nofit);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[conv2d_padded_nhwc_engine_unit.f]
sv/c2d_pkg.sv
sv/conv2d_padded_nhwc_engine_unit.sv
test/testbench.sv
